// ===== src/tach_pkg.sv =====
// Shared types and constants for the encoder pulse tachometer.
package tach_pkg;

    localparam int DW   = 32;
    localparam int PDW  = 8;
    localparam int IDXW = 2;
    localparam int CMDW = 2;
    localparam int CFGW = 2;

    localparam logic [CMDW-1:0] CMD_PULSE = 2'd0;
    localparam logic [CMDW-1:0] CMD_ROLL  = 2'd1;
    localparam logic [CMDW-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CFGW-1:0] CFG_ROLLOVER = 2'd0;
    localparam logic [CFGW-1:0] CFG_SPEED    = 2'd1;
    localparam logic [CFGW-1:0] CFG_PDIST    = 2'd2;

    localparam logic [DW-1:0]  RST_ROLLOVER = 32'd40800000;
    localparam logic [DW-1:0]  RST_SPEED    = 32'd224400000;
    localparam logic [PDW-1:0] RST_PDIST    = 8'd1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CALC = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    typedef struct packed {
        logic [DW-1:0] last;
        logic [DW-1:0] speed;
        logic [DW-1:0] odo;
    } t_entry;

    typedef struct packed {
        logic          start;
        logic [DW-1:0] dividend;
        logic [DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic          done;
        logic [DW-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== src/encoder_pulse_tachometer.sv =====
// Top level: encoder period, speed and odometer tracking over a shared state memory.
// A transaction goes CALC, then DIV if a pulse needs a divide, then DONE.
// A new transaction waits until the previous one, with any 32-step divide, is done.
// The next transaction is taken while a finished result waits in the output register.
// Reset: synchronous, clears flags and entry valid bits; no clearing pass.
// Registers reset to rollover 40800000, speed constant 224400000, pulse distance 1.
module encoder_pulse_tachometer #(
    parameter int NUM_ENCODERS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [tach_pkg::CMDW-1:0]     i_command,
    input  logic [tach_pkg::IDXW-1:0]     i_encoder_index,
    input  logic [tach_pkg::DW-1:0]       i_timer_count,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [tach_pkg::IDXW-1:0]     o_encoder_index_out,
    output logic [tach_pkg::DW-1:0]       o_speed,
    output logic [tach_pkg::DW-1:0]       o_distance,
    input  logic                          i_cfg_we,
    input  logic [tach_pkg::CFGW-1:0]     i_cfg_index,
    input  logic [tach_pkg::DW-1:0]       i_cfg_data
);
    import tach_pkg::*;

    localparam int AW = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

    t_state                  r_state;
    logic [CMDW-1:0]         r_cmd;
    logic [IDXW-1:0]         r_idx;
    logic [DW-1:0]           r_tc;
    logic [DW-1:0]           r_rp;
    logic [DW-1:0]           r_sc;
    logic [PDW-1:0]          r_pd;
    logic [NUM_ENCODERS-1:0] r_rolled;
    logic [NUM_ENCODERS-1:0] r_szero;
    t_entry                  r_new;
    logic                    r_wr;
    logic                    r_ovalid;
    logic [IDXW-1:0]         r_oidx;
    logic [DW-1:0]           r_ospeed;
    logic [DW-1:0]           r_odist;

    logic                    w_accept;
    logic [AW-1:0]           w_addr;
    logic                    w_inr;
    t_entry                  w_ent;
    logic                    w_rolled;
    logic [DW-1:0]           w_spd;
    logic [DW-1:0]           w_span;
    logic                    w_span_hi;
    logic                    w_span_zero;
    logic                    w_go;
    t_div_req                w_div_req;
    t_div_rsp                w_div_rsp;

    assign w_accept = i_valid && !o_stall;
    assign w_addr   = AW'(r_idx);
    assign w_inr    = (int'(r_idx) < NUM_ENCODERS);
    assign w_go     = (r_state == ST_DONE) && (!r_ovalid || !i_stall);

    always_comb begin
        w_rolled    = w_inr && r_rolled[w_addr];
        w_spd       = (w_inr && r_szero[w_addr]) ? '0 : w_ent.speed;
        w_span      = w_rolled ? (r_tc + (r_rp - w_ent.last)) : (r_tc - w_ent.last);
        w_span_hi   = (w_span >= r_rp);
        w_span_zero = (w_span == '0);
        w_div_req.start    = (r_state == ST_CALC) && (r_cmd == CMD_PULSE) && w_inr
                             && !w_span_hi && !w_span_zero;
        w_div_req.dividend = r_sc;
        w_div_req.divisor  = w_span;
    end

    tach_mem #(
        .NUM_ENCODERS(NUM_ENCODERS),
        .AW          (AW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (w_accept),
        .i_rd_addr(AW'(i_encoder_index)),
        .i_wr_en  (w_go && r_wr),
        .i_wr_addr(w_addr),
        .i_wr_data(r_new),
        .o_rd_data(w_ent)
    );

    tach_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div_req),
        .o_rsp  (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp <= RST_ROLLOVER;
            r_sc <= RST_SPEED;
            r_pd <= RST_PDIST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROLLOVER: r_rp <= i_cfg_data;
                CFG_SPEED:    r_sc <= i_cfg_data;
                CFG_PDIST:    r_pd <= i_cfg_data[PDW-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rolled <= '0;
            r_szero  <= '0;
            r_wr     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_go) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_cmd   <= i_command;
                        r_idx   <= i_encoder_index;
                        r_tc    <= i_timer_count;
                        r_state <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    r_wr      <= 1'b0;
                    r_new     <= '{last: w_ent.last, speed: w_spd, odo: w_ent.odo};
                    r_state   <= ST_DONE;
                    case (r_cmd)
                        CMD_PULSE: begin
                            if (w_inr) begin
                                r_wr               <= 1'b1;
                                r_rolled[w_addr]   <= 1'b0;
                                r_new.last         <= r_tc;
                                r_new.odo          <= w_ent.odo + DW'(r_pd);
                                if (w_span_hi) begin
                                    r_new.speed <= '0;
                                end else if (w_span_zero) begin
                                    r_new.speed <= r_sc;
                                end else begin
                                    r_state <= ST_DIV;
                                end
                            end
                        end
                        CMD_ROLL: begin
                            for (int i = 0; i < NUM_ENCODERS; i++) begin
                                if (r_rolled[i]) begin
                                    r_szero[i]  <= 1'b1;
                                    r_rolled[i] <= 1'b0;
                                end else begin
                                    r_rolled[i] <= 1'b1;
                                end
                            end
                            if (w_rolled) begin
                                r_new.speed <= '0;
                            end
                        end
                        CMD_CLEAR: begin
                            if (w_inr) begin
                                r_wr      <= 1'b1;
                                r_new.odo <= '0;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_DIV: begin
                    if (w_div_rsp.done) begin
                        r_new.speed <= w_div_rsp.quotient;
                        r_state     <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_go) begin
                        r_oidx   <= r_idx;
                        r_ospeed <= w_inr ? r_new.speed : '0;
                        r_odist  <= w_inr ? r_new.odo : '0;
                        if (r_wr) begin
                            r_szero[w_addr] <= 1'b0;
                        end
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stall             = (r_state != ST_IDLE);
    assign o_valid             = r_ovalid;
    assign o_encoder_index_out = r_oidx;
    assign o_speed             = r_ospeed;
    assign o_distance          = r_odist;

endmodule

// ===== src/tach_div.sv =====
// Restoring divider, one quotient bit per cycle.
module tach_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tach_pkg::t_div_req i_req,
    output tach_pkg::t_div_rsp o_rsp
);
    import tach_pkg::*;

    localparam int CNTW = $clog2(DW);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_quo;
    logic [DW-1:0]   r_div;

    logic [DW:0]     w_trial;
    logic [DW:0]     w_diff;
    logic            w_ge;
    logic [DW-1:0]   n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[DW-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
        n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[DW-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== src/tach_mem.sv =====
// Per-encoder state memory with registered read and entry valid bits.
module tach_mem #(
    parameter int NUM_ENCODERS = 4,
    parameter int AW           = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  tach_pkg::t_entry i_wr_data,
    output tach_pkg::t_entry o_rd_data
);
    import tach_pkg::*;

    t_entry                  r_mem [NUM_ENCODERS];
    logic [NUM_ENCODERS-1:0] r_vld;
    t_entry                  r_rdata;
    logic                    r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rvld <= (int'(i_rd_addr) < NUM_ENCODERS) && r_vld[i_rd_addr];
            end
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rvld ? r_rdata : '0;

endmodule
